@@ design/ic3_pkg.sv @@
`timescale 1ns / 1ps

package ic3_pkg;

    // Frame geometry limits and arithmetic widths.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 16;
    localparam int WCMP_W    = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
    localparam int OUT_COL_W = 10;

    localparam int KSIZE     = 3;
    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;
    localparam int FRAC      = 12;
    localparam int COEF_ROW_W = KSIZE * COEF_W;
    localparam int PROD_W    = PIX_W + 1 + COEF_W;
    localparam int CSUM_W    = PROD_W + 2;
    localparam int SUM_W     = CSUM_W + 2;

    // Configuration port.
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEF_TOP     = 3'd2,
        REG_COEF_MIDDLE  = 3'd3,
        REG_COEF_BOTTOM  = 3'd4
    } ic3_reg_t;

    localparam logic [COEF_ROW_W-1:0] COEF_MIDDLE_RESET = 48'h0000_1000_0000;

    // Pixel column held by one cell, top row at index 0.
    typedef logic [KSIZE-1:0][PIX_W-1:0]  ic3_col_t;
    typedef logic [KSIZE-1:0][COEF_W-1:0] ic3_coef_col_t;

    // Per-cycle controls that the top level hands to every cell.
    typedef struct packed {
        logic shift;
        logic prod_en;
        logic sum_en;
    } ic3_cell_ctl_t;

endpackage

@@ design/ic3_line_store.sv @@
`timescale 1ns / 1ps

module ic3_line_store (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ic3_pkg::COL_W-1:0] wr_addr,
    input  logic [2*ic3_pkg::PIX_W-1:0] wr_data,
    input  logic [ic3_pkg::COL_W-1:0] rd_addr,
    output logic [2*ic3_pkg::PIX_W-1:0] rd_data
);

    // Both line stores share one word: upper row in the high byte, lower row in the low byte.
    logic [2*ic3_pkg::PIX_W-1:0] mem_q [ic3_pkg::MAX_WIDTH];
    logic [2*ic3_pkg::PIX_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_q[wr_addr] <= wr_data;
        end
    end

    // Registered read; a same-address write is forwarded so the read sees new data.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem_q[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/ic3_cell.sv @@
`timescale 1ns / 1ps

module ic3_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ic3_pkg::ic3_cell_ctl_t              ctl,
    input  ic3_pkg::ic3_col_t                   col_in,
    input  ic3_pkg::ic3_coef_col_t              coef,
    output ic3_pkg::ic3_col_t                   col_out,
    output logic signed [ic3_pkg::CSUM_W-1:0]   col_sum
);

    ic3_pkg::ic3_col_t                  pix_reg;
    logic signed [ic3_pkg::PROD_W-1:0]  prod_reg [ic3_pkg::KSIZE];
    logic signed [ic3_pkg::CSUM_W-1:0]  sum_next;
    logic signed [ic3_pkg::CSUM_W-1:0]  sum_reg;

    // Window column; takes the neighbor's column on every accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else if (ctl.shift)
        begin
            pix_reg <= col_in;
        end
    end

    // One product per row of the column.
    always_ff @(posedge clk)
    begin
        if (ctl.prod_en)
        begin
            for (int i = 0; i < ic3_pkg::KSIZE; i++)
            begin
                prod_reg[i] <= $signed({1'b0, pix_reg[i]}) * $signed(coef[i]);
            end
        end
    end

    // Column sum of the registered products.
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < ic3_pkg::KSIZE; i++)
        begin
            sum_next = sum_next + ic3_pkg::CSUM_W'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign col_out = pix_reg;
    assign col_sum = sum_reg;

endmodule

@@ design/image_convolution_3x3.sv @@
`timescale 1ns / 1ps

// Streaming 3x3 filter for 8-bit grayscale frames in raster order. The block takes one
// pixel beat per clock while in_stall is low, and each result beat passes from the pixel
// that completes its neighborhood through the window cells, the products, the column sums
// and the total, then the rounded and clamped value sits in the output register. Border
// pixels produce no beat. The two line stores are one 1024-word memory read one column
// ahead of the incoming pixel, and the window is a row of three cells that hand their
// pixel column to the neighbor on every beat. A full pipeline holds five results; in_stall
// rises only when all of them wait on out_stall. Line store contents are undefined after
// reset and need no clearing pass; the first two rows of a frame fill them. Registers sit
// at byte address 8*i on the 64-bit port; the user must write them only while no pixel is
// in flight, which the block itself does not enforce.
module image_convolution_3x3 (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ic3_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ic3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ic3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // Pixel input channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ic3_pkg::PIX_W-1:0]          pixel,
    // Result channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ic3_pkg::PIX_W-1:0]          value,
    output logic [ic3_pkg::ROW_W-1:0]          out_row,
    output logic [ic3_pkg::OUT_COL_W-1:0]      out_col,
    output logic                               last_pixel
);

    typedef struct packed {
        logic [ic3_pkg::ROW_W-1:0]     row;
        logic [ic3_pkg::OUT_COL_W-1:0] col;
        logic                          last;
    } meta_t;

    localparam logic [ic3_pkg::FRAC-1:0] HALF = {1'b1, {(ic3_pkg::FRAC-1){1'b0}}};
    localparam int Q_W = ic3_pkg::SUM_W - ic3_pkg::FRAC + 1;

    // Round to nearest, ties to even, then clamp to the pixel range.
    function automatic logic [ic3_pkg::PIX_W-1:0] round_clamp(
        input logic signed [ic3_pkg::SUM_W-1:0] s
    );
        logic signed [Q_W-1:0]        q;
        logic [ic3_pkg::FRAC-1:0]     rem;
        logic                         rnd_up;
        logic [ic3_pkg::PIX_W-1:0]    res;
        q      = Q_W'(s >>> ic3_pkg::FRAC);
        rem    = s[ic3_pkg::FRAC-1:0];
        rnd_up = (rem > HALF) || ((rem == HALF) && q[0]);
        q      = q + Q_W'(rnd_up);
        if (q < 0)
        begin
            res = '0;
        end
        else if (q > 255)
        begin
            res = '1;
        end
        else
        begin
            res = q[ic3_pkg::PIX_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [ic3_pkg::WIDTH_W-1:0]     width_reg;
    logic [ic3_pkg::HEIGHT_W-1:0]    height_reg;
    logic [ic3_pkg::COEF_ROW_W-1:0]  coef_top_reg;
    logic [ic3_pkg::COEF_ROW_W-1:0]  coef_mid_reg;
    logic [ic3_pkg::COEF_ROW_W-1:0]  coef_bot_reg;
    logic                            cfg_wr;
    ic3_pkg::ic3_reg_t               cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = ic3_pkg::ic3_reg_t'(paddr[ic3_pkg::APB_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= ic3_pkg::WIDTH_W'(1024);
            height_reg   <= ic3_pkg::HEIGHT_W'(1024);
            coef_top_reg <= '0;
            coef_mid_reg <= ic3_pkg::COEF_MIDDLE_RESET;
            coef_bot_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                ic3_pkg::REG_IMAGE_WIDTH:  width_reg    <= pwdata[ic3_pkg::WIDTH_W-1:0];
                ic3_pkg::REG_IMAGE_HEIGHT: height_reg   <= pwdata[ic3_pkg::HEIGHT_W-1:0];
                ic3_pkg::REG_COEF_TOP:     coef_top_reg <= pwdata[ic3_pkg::COEF_ROW_W-1:0];
                ic3_pkg::REG_COEF_MIDDLE:  coef_mid_reg <= pwdata[ic3_pkg::COEF_ROW_W-1:0];
                ic3_pkg::REG_COEF_BOTTOM:  coef_bot_reg <= pwdata[ic3_pkg::COEF_ROW_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_sel)
            ic3_pkg::REG_IMAGE_WIDTH:  prdata = ic3_pkg::APB_DATA_W'(width_reg);
            ic3_pkg::REG_IMAGE_HEIGHT: prdata = ic3_pkg::APB_DATA_W'(height_reg);
            ic3_pkg::REG_COEF_TOP:     prdata = ic3_pkg::APB_DATA_W'(coef_top_reg);
            ic3_pkg::REG_COEF_MIDDLE:  prdata = ic3_pkg::APB_DATA_W'(coef_mid_reg);
            ic3_pkg::REG_COEF_BOTTOM:  prdata = ic3_pkg::APB_DATA_W'(coef_bot_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage moves when the next one has room.
    // ------------------------------------------------------------------
    logic valid0_reg, valid1_reg, valid2_reg, valid3_reg, out_valid_reg;
    logic ready0, ready1, ready2, ready3, ready4;
    logic accept;

    assign ready4   = !out_valid_reg || !out_stall;
    assign ready3   = !valid3_reg || ready4;
    assign ready2   = !valid2_reg || ready3;
    assign ready1   = !valid1_reg || ready2;
    assign ready0   = !valid0_reg || ready1;
    assign in_stall = !ready0;
    assign accept   = in_valid && ready0;

    // ------------------------------------------------------------------
    // Position counters.
    // ------------------------------------------------------------------
    logic [ic3_pkg::COL_W-1:0]   col_reg, col_next;
    logic [ic3_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [ic3_pkg::WCMP_W-1:0]  width_ext, width_last;
    logic [ic3_pkg::HEIGHT_W-1:0] height_last;
    logic                        row_end, frame_end, emit;

    always_comb
    begin
        width_ext = ic3_pkg::WCMP_W'(width_reg);
        priority if (width_ext == '0)
        begin
            width_last = '0;
        end
        else if (width_ext > ic3_pkg::WCMP_W'(ic3_pkg::MAX_WIDTH))
        begin
            width_last = ic3_pkg::WCMP_W'(ic3_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            width_last = width_ext - 1'b1;
        end
        height_last = (height_reg == '0) ? '0 : height_reg - 1'b1;
        row_end     = ic3_pkg::WCMP_W'(col_reg) >= width_last;
        frame_end   = row_end && (row_reg >= height_last);
        emit        = (row_reg >= ic3_pkg::ROW_W'(2)) && (col_reg >= ic3_pkg::COL_W'(2));
        col_next    = row_end ? '0 : col_reg + 1'b1;
        row_next    = !row_end ? row_reg : (frame_end ? '0 : row_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores, read one column ahead so the data waits for the pixel.
    // ------------------------------------------------------------------
    logic [2*ic3_pkg::PIX_W-1:0] line_rd;
    logic [ic3_pkg::PIX_W-1:0]   line_up, line_mid;
    logic [ic3_pkg::COL_W-1:0]   line_rd_addr;

    assign line_rd_addr = accept ? col_next : col_reg;
    assign line_up      = line_rd[2*ic3_pkg::PIX_W-1:ic3_pkg::PIX_W];
    assign line_mid     = line_rd[ic3_pkg::PIX_W-1:0];

    ic3_line_store u_line_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data ({line_mid, pixel}),
        .rd_addr (line_rd_addr),
        .rd_data (line_rd)
    );

    // ------------------------------------------------------------------
    // Row of window cells; cell 0 holds the newest column.
    // ------------------------------------------------------------------
    ic3_pkg::ic3_cell_ctl_t             cell_ctl;
    ic3_pkg::ic3_col_t                  cell_in   [ic3_pkg::KSIZE];
    ic3_pkg::ic3_col_t                  cell_out  [ic3_pkg::KSIZE];
    ic3_pkg::ic3_coef_col_t             cell_coef [ic3_pkg::KSIZE];
    logic signed [ic3_pkg::CSUM_W-1:0]  cell_sum  [ic3_pkg::KSIZE];
    logic [ic3_pkg::KSIZE-1:0][ic3_pkg::COEF_ROW_W-1:0] coef_rows;

    assign coef_rows = {coef_bot_reg, coef_mid_reg, coef_top_reg};
    assign cell_ctl.shift   = accept;
    assign cell_ctl.prod_en = valid0_reg && ready1;
    assign cell_ctl.sum_en  = valid1_reg && ready2;
    assign cell_in[0]       = {pixel, line_mid, line_up};

    for (genvar k = 0; k < ic3_pkg::KSIZE; k++)
    begin : g_cell
        if (k > 0)
        begin : g_link
            assign cell_in[k] = cell_out[k-1];
        end

        // Cell k sits at kernel column KSIZE-1-k.
        for (genvar i = 0; i < ic3_pkg::KSIZE; i++)
        begin : g_coef
            assign cell_coef[k][i] =
                coef_rows[i][(ic3_pkg::KSIZE-1-k)*ic3_pkg::COEF_W +: ic3_pkg::COEF_W];
        end

        ic3_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cell_ctl),
            .col_in  (cell_in[k]),
            .coef    (cell_coef[k]),
            .col_out (cell_out[k]),
            .col_sum (cell_sum[k])
        );
    end

    // ------------------------------------------------------------------
    // Total of the column sums.
    // ------------------------------------------------------------------
    logic signed [ic3_pkg::SUM_W-1:0] total_next, total_reg;

    always_comb
    begin
        total_next = '0;
        for (int k = 0; k < ic3_pkg::KSIZE; k++)
        begin
            total_next = total_next + ic3_pkg::SUM_W'(cell_sum[k]);
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and position tags that travel with each beat.
    // ------------------------------------------------------------------
    meta_t meta_new, meta0_reg, meta1_reg, meta2_reg, meta3_reg;

    assign meta_new.row  = row_reg - 1'b1;
    assign meta_new.col  = ic3_pkg::OUT_COL_W'(col_reg - 1'b1);
    assign meta_new.last = frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg    <= 1'b0;
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            valid3_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
            begin
                valid0_reg <= accept && emit;
            end
            if (ready1)
            begin
                valid1_reg <= valid0_reg;
            end
            if (ready2)
            begin
                valid2_reg <= valid1_reg;
            end
            if (ready3)
            begin
                valid3_reg <= valid2_reg;
            end
            if (ready4)
            begin
                out_valid_reg <= valid3_reg;
            end
        end
    end

    // Payload registers of each stage.
    logic [ic3_pkg::PIX_W-1:0] value_reg;
    meta_t                     out_meta_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meta0_reg <= meta_new;
        end
        if (valid0_reg && ready1)
        begin
            meta1_reg <= meta0_reg;
        end
        if (valid1_reg && ready2)
        begin
            meta2_reg <= meta1_reg;
        end
        if (valid2_reg && ready3)
        begin
            meta3_reg <= meta2_reg;
            total_reg <= total_next;
        end
        if (valid3_reg && ready4)
        begin
            out_meta_reg <= meta3_reg;
            value_reg    <= round_clamp(total_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign out_row    = out_meta_reg.row;
    assign out_col    = out_meta_reg.col;
    assign last_pixel = out_meta_reg.last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Input backs up only when every pipeline slot holds a result.
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (valid0_reg && valid1_reg && valid2_reg && valid3_reg && out_valid_reg)
    ) else $error("input stalled with room in the pipeline");

    // A one-pixel row rereads the column just written; the forward must deliver it.
    a_line_forward: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && (col_next == col_reg)) |=> (line_rd == $past({line_mid, pixel}))
    ) else $error("line store forward returned stale data");

    // Counters restart at the start of a row after its last pixel.
    a_row_wrap: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && row_end) |=> (col_reg == '0)
    ) else $error("column counter did not wrap at row end");

endmodule
